### sv/wrsp_pkg.sv
// Package with the shared types and constants of the WAV stream parser.
package wrsp_pkg;

  typedef enum logic [2:0] {
    PH_HEADER, PH_CHUNK_HDR, PH_FMT, PH_DATA, PH_SKIP, PH_PAD, PH_BAD
  } phase_t;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_INFO   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_NOT_RIFF  = 3'd2;
  localparam logic [2:0] ST_TRUNC     = 3'd3;
  localparam logic [2:0] ST_NO_FMT    = 3'd4;
  localparam logic [2:0] ST_BAD_CHANS = 3'd5;
  localparam logic [2:0] ST_BAD_FMT   = 3'd6;
  localparam logic [2:0] ST_UNALIGNED = 3'd7;

  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] FMT_PCM   = 16'h0001;
  localparam logic [15:0] FMT_FLOAT = 16'h0003;
  localparam logic [15:0] FMT_EXT   = 16'hFFFE;

  // One transaction passed from the front part to the back part.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] raw;
    logic        conv_float;
    logic [5:0]  conv_bits;
    logic [4:0]  channel_index;
    logic [18:0] sample_rate;
    logic [5:0]  channel_count;
    logic [5:0]  bits_per_sample;
    logic        is_float;
    logic [2:0]  status_code;
    logic        last;
  } item_t;

endpackage

### sv/wrsp_front.sv
// Front part of the WAV parser: walks headers and chunks and queues transactions.
module wrsp_front import wrsp_pkg::*; #(
  parameter int MAX_CHANNELS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [7:0]  file_byte,
  input  logic        end_of_file,
  input  logic [1:0]  free_slots,
  output logic        in_stall,
  output logic        push_a,
  output item_t       item_a,
  output logic        push_b,
  output item_t       item_b
);

  phase_t      parse_phase, parse_phase_next;
  logic [31:0] byte_position;
  logic [31:0] chunk_tag;
  logic [31:0] chunk_remaining;
  logic        pad_pending;
  logic [15:0] format_tag;
  logic [31:0] format_chunk_size;
  logic [31:0] rate_held;
  logic [15:0] channels_held;
  logic [15:0] bits_held;
  logic [15:0] sub_format;
  logic [31:0] sample_assembly;
  logic [1:0]  byte_in_sample;
  logic [4:0]  channel_counter;
  logic [2:0]  header_count;
  logic        seen_fmt, seen_data, seen_err;
  logic        chk_fmt_bad, chk_chans_bad;

  logic        take;
  logic [31:0] off;
  logic [15:0] eff_fmt;
  logic [2:0]  fcheck;
  logic [31:0] tag_new, rem_new, asm_new, rem_dec;
  logic        open_now, sample_done, info_now;
  logic [2:0]  status_now;
  logic        end_by_zero;

  function automatic logic [7:0] riff_byte(input logic [1:0] i);
    unique case (i)
      2'd0: riff_byte = 8'h52;
      2'd1: riff_byte = 8'h49;
      2'd2: riff_byte = 8'h46;
      default: riff_byte = 8'h46;
    endcase
  endfunction

  function automatic logic [7:0] wave_byte(input logic [1:0] i);
    unique case (i)
      2'd0: wave_byte = 8'h57;
      2'd1: wave_byte = 8'h41;
      2'd2: wave_byte = 8'h56;
      default: wave_byte = 8'h45;
    endcase
  endfunction

  assign in_stall = (free_slots < 2'd2);
  assign take = in_valid && !in_stall;

  assign eff_fmt = (format_tag == FMT_EXT && format_chunk_size >= 32'd40) ?
                   sub_format : format_tag;

  assign chk_fmt_bad = !seen_fmt || format_chunk_size < 32'd16;
  assign chk_chans_bad = channels_held < 16'd1 ||
                         channels_held > 16'(MAX_CHANNELS) ||
                         rate_held < 32'd8000 || rate_held > 32'd384000;

  always_comb begin
    if (chk_fmt_bad) begin
      fcheck = ST_NO_FMT;
    end else if (chk_chans_bad) begin
      fcheck = ST_BAD_CHANS;
    end else if (eff_fmt == FMT_PCM &&
                 (bits_held == 16'd16 || bits_held == 16'd24 || bits_held == 16'd32)) begin
      fcheck = ST_OK;
    end else if (eff_fmt == FMT_FLOAT && bits_held == 16'd32) begin
      fcheck = ST_OK;
    end else begin
      fcheck = ST_BAD_FMT;
    end
  end

  assign off = format_chunk_size - chunk_remaining;
  assign rem_dec = chunk_remaining - 32'd1;

  always_comb begin
    tag_new = chunk_tag;
    rem_new = chunk_remaining;
    unique case (header_count)
      3'd0: tag_new = {24'd0, file_byte};
      3'd1: tag_new[15:8] = file_byte;
      3'd2: tag_new[23:16] = file_byte;
      3'd3: tag_new[31:24] = file_byte;
      3'd4: rem_new = {24'd0, file_byte};
      3'd5: rem_new[15:8] = file_byte;
      3'd6: rem_new[23:16] = file_byte;
      3'd7: rem_new[31:24] = file_byte;
      default: ;
    endcase
  end

  always_comb begin
    asm_new = sample_assembly;
    unique case (byte_in_sample)
      2'd0: asm_new[7:0] = file_byte;
      2'd1: asm_new[15:8] = file_byte;
      2'd2: asm_new[23:16] = file_byte;
      2'd3: asm_new[31:24] = file_byte;
      default: ;
    endcase
  end

  assign open_now = parse_phase == PH_CHUNK_HDR && header_count == 3'd7;
  assign info_now = open_now && tag_new == TAG_DATA && !seen_data && fcheck == ST_OK;
  assign sample_done = parse_phase == PH_DATA &&
                       ({1'b0, byte_in_sample} + 3'd1) >= bits_held[5:3];

  // Work out the phase and flags that this byte leaves, for the status check.
  logic   open_fmt, open_data;
  logic   err_add;
  phase_t after_phase;
  logic   after_data, after_fmt, after_err;
  logic [31:0] pos_next;

  assign open_fmt  = open_now && tag_new == TAG_FMT && !seen_data;
  assign open_data = open_now && tag_new == TAG_DATA && !seen_data;

  always_comb begin
    after_phase = parse_phase;
    end_by_zero = 1'b0;
    err_add = 1'b0;
    unique case (parse_phase)
      PH_HEADER: begin
        if (byte_position < 32'd4 && file_byte != riff_byte(byte_position[1:0])) begin
          after_phase = PH_BAD;
        end else if (byte_position >= 32'd8 && byte_position < 32'd12 &&
                     file_byte != wave_byte(byte_position[1:0])) begin
          after_phase = PH_BAD;
        end else if (byte_position >= 32'd11) begin
          after_phase = PH_CHUNK_HDR;
        end
      end
      PH_CHUNK_HDR: begin
        if (open_now) begin
          if (open_fmt) after_phase = PH_FMT;
          else if (info_now) after_phase = PH_DATA;
          else after_phase = PH_SKIP;
          if (rem_new == 32'd0) begin
            end_by_zero = 1'b1;
            after_phase = rem_new[0] ? PH_PAD : PH_CHUNK_HDR;
          end
        end
      end
      PH_FMT, PH_DATA, PH_SKIP: begin
        if (rem_dec == 32'd0) begin
          end_by_zero = 1'b1;
          after_phase = pad_pending ? PH_PAD : PH_CHUNK_HDR;
          if (parse_phase == PH_DATA) begin
            if (sample_done) begin
              err_add = (16'(channel_counter) + 16'd1 < channels_held);
            end else begin
              err_add = 1'b1;
            end
          end
        end
      end
      PH_PAD: after_phase = PH_CHUNK_HDR;
      default: ;
    endcase
    parse_phase_next = after_phase;
  end

  assign after_fmt  = seen_fmt || open_fmt;
  assign after_data = seen_data || open_data;
  assign after_err  = seen_err || err_add;
  assign pos_next = (byte_position == 32'hFFFF_FFFF) ? byte_position :
                    byte_position + 32'd1;

  // Status: the format registers are unchanged by the bytes that matter here,
  // except a fmt chunk opened by this byte, which leaves the phase in fmt.
  always_comb begin
    if (pos_next < 32'd44) begin
      status_now = ST_SHORT;
    end else if (after_phase == PH_BAD || after_phase == PH_HEADER) begin
      status_now = ST_NOT_RIFF;
    end else if (after_phase == PH_FMT || after_phase == PH_DATA ||
                 after_phase == PH_SKIP) begin
      status_now = ST_TRUNC;
    end else if (!after_data) begin
      status_now = ST_NO_FMT;
    end else if (open_fmt) begin
      status_now = ST_NO_FMT;
    end else if (fcheck != ST_OK || !after_fmt) begin
      status_now = fcheck;
    end else begin
      status_now = after_err ? ST_UNALIGNED : ST_OK;
    end
  end

  always_comb begin
    item_a = '0;
    item_b = '0;
    push_a = 1'b0;
    push_b = 1'b0;
    if (take) begin
      if (info_now) begin
        push_a = 1'b1;
        item_a.kind = KIND_INFO;
        item_a.sample_rate = rate_held[18:0];
        item_a.channel_count = channels_held[5:0];
        item_a.bits_per_sample = bits_held[5:0];
        item_a.is_float = (eff_fmt == FMT_FLOAT);
      end else if (sample_done) begin
        push_a = 1'b1;
        item_a.kind = KIND_SAMPLE;
        item_a.raw = asm_new;
        item_a.conv_float = (eff_fmt == FMT_FLOAT);
        item_a.conv_bits = bits_held[5:0];
        item_a.channel_index = channel_counter;
      end
      if (end_of_file) begin
        push_b = 1'b1;
        item_b.kind = KIND_STATUS;
        item_b.status_code = status_now;
        item_b.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && end_of_file)) begin
      parse_phase <= PH_HEADER;
      byte_position <= '0;
      chunk_tag <= '0;
      chunk_remaining <= '0;
      pad_pending <= 1'b0;
      format_tag <= '0;
      format_chunk_size <= '0;
      rate_held <= '0;
      channels_held <= '0;
      bits_held <= '0;
      sub_format <= '0;
      sample_assembly <= '0;
      byte_in_sample <= '0;
      channel_counter <= '0;
      header_count <= '0;
      seen_fmt <= 1'b0;
      seen_data <= 1'b0;
      seen_err <= 1'b0;
    end else if (take) begin
      parse_phase <= parse_phase_next;
      byte_position <= pos_next;
      seen_err <= after_err;
      if (parse_phase == PH_HEADER || parse_phase == PH_PAD || end_by_zero) begin
        header_count <= '0;
      end
      if (parse_phase == PH_CHUNK_HDR) begin
        chunk_tag <= tag_new;
        chunk_remaining <= rem_new;
        header_count <= header_count + 3'd1;
        if (open_now) begin
          pad_pending <= end_by_zero ? 1'b0 : rem_new[0];
          if (open_fmt) begin
            seen_fmt <= 1'b1;
            format_chunk_size <= rem_new;
            format_tag <= '0;
            channels_held <= '0;
            rate_held <= '0;
            bits_held <= '0;
            sub_format <= '0;
          end
          if (open_data) seen_data <= 1'b1;
          if (info_now) begin
            sample_assembly <= '0;
            byte_in_sample <= '0;
            channel_counter <= '0;
          end
        end
      end
      if (parse_phase == PH_FMT || parse_phase == PH_DATA || parse_phase == PH_SKIP) begin
        chunk_remaining <= rem_dec;
        if (end_by_zero) pad_pending <= 1'b0;
      end
      if (parse_phase == PH_FMT) begin
        if (off == 32'd0) format_tag[7:0] <= file_byte;
        else if (off == 32'd1) format_tag[15:8] <= file_byte;
        else if (off == 32'd2) channels_held[7:0] <= file_byte;
        else if (off == 32'd3) channels_held[15:8] <= file_byte;
        else if (off == 32'd4) rate_held[7:0] <= file_byte;
        else if (off == 32'd5) rate_held[15:8] <= file_byte;
        else if (off == 32'd6) rate_held[23:16] <= file_byte;
        else if (off == 32'd7) rate_held[31:24] <= file_byte;
        else if (off == 32'd14) bits_held[7:0] <= file_byte;
        else if (off == 32'd15) bits_held[15:8] <= file_byte;
        else if (off == 32'd24) sub_format[7:0] <= file_byte;
        else if (off == 32'd25) sub_format[15:8] <= file_byte;
      end
      if (parse_phase == PH_DATA) begin
        if (sample_done) begin
          sample_assembly <= '0;
          byte_in_sample <= '0;
          channel_counter <= (16'(channel_counter) + 16'd1 >= channels_held) ?
                             5'd0 : channel_counter + 5'd1;
        end else begin
          sample_assembly <= asm_new;
          byte_in_sample <= byte_in_sample + 2'd1;
        end
      end
    end
  end

endmodule

### sv/wrsp_queue.sv
// Small queue between the front and back parts, taking up to two entries a cycle.
module wrsp_queue import wrsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_a,
  input  item_t      item_a,
  input  logic       push_b,
  input  item_t      item_b,
  output logic [1:0] free_slots,
  output logic       pop_valid,
  output item_t      pop_item,
  input  logic       pop
);

  localparam int DEPTH = 4;

  item_t      mem [DEPTH];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic [2:0] n_push;
  logic [2:0] free_w;

  assign n_push = {2'd0, push_a} + {2'd0, push_b};
  assign free_w = 3'(DEPTH) - count;
  assign free_slots = (free_w > 3'd3) ? 2'd3 : free_w[1:0];
  assign pop_valid = count != 3'd0;
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem[wr_ptr] <= item_a;
      if (push_b) mem[wr_ptr + 2'd1] <= item_b;
    end else if (push_b) begin
      mem[wr_ptr] <= item_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[1:0];
      if (pop && pop_valid) rd_ptr <= rd_ptr + 2'd1;
      count <= count + n_push - {2'd0, pop && pop_valid};
    end
  end

endmodule

### sv/wrsp_back.sv
// Back part of the WAV parser: converts samples and holds the output register.
module wrsp_back import wrsp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  input  item_t              pop_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic signed [31:0] sample_value,
  output logic [4:0]         channel_index,
  output logic [18:0]        sample_rate,
  output logic [5:0]         channel_count,
  output logic [5:0]         bits_per_sample,
  output logic               is_float,
  output logic [2:0]         status_code,
  output logic               last
);

  logic [31:0] conv;
  logic [7:0]  e;
  logic [23:0] mant;
  logic [31:0] mag;

  assign e = pop_item.raw[30:23];
  assign mant = {1'b1, pop_item.raw[22:0]};

  always_comb begin
    mag = '0;
    if (e >= 8'd119) mag = {8'd0, mant} << (e - 8'd119);
    else if (8'd119 - e < 8'd24) mag = {8'd0, mant} >> (8'd119 - e);
  end

  always_comb begin
    if (pop_item.kind != KIND_SAMPLE) begin
      conv = '0;
    end else if (pop_item.conv_float) begin
      if (e == 8'hFF || e == 8'h00) conv = '0;
      else if (e >= 8'd127) conv = pop_item.raw[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else conv = pop_item.raw[31] ? (32'd0 - mag) : mag;
    end else if (pop_item.conv_bits == 6'd16) begin
      conv = {pop_item.raw[15:0], 16'd0};
    end else if (pop_item.conv_bits == 6'd24) begin
      conv = {pop_item.raw[23:0], 8'd0};
    end else begin
      conv = pop_item.raw;
    end
  end

  assign pop = pop_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind <= pop_item.kind;
      sample_value <= conv;
      channel_index <= pop_item.channel_index;
      sample_rate <= pop_item.sample_rate;
      channel_count <= pop_item.channel_count;
      bits_per_sample <= pop_item.bits_per_sample;
      is_float <= pop_item.is_float;
      status_code <= pop_item.status_code;
      last <= pop_item.last;
    end
  end

endmodule

### sv/wav_riff_stream_parser.sv
// Top level of the WAV stream parser.
// Takes one file byte per cycle and gives sample, stream info and final status
// transactions. A byte is taken every cycle while the four-entry result queue
// has two free entries; a byte yields at most two results, drained at one per
// cycle through the output register while out_stall is low, so the rate is
// one byte per cycle, the per-cycle output port limiting it when results bunch up.
module wav_riff_stream_parser import wrsp_pkg::*; #(
  parameter int MAX_CHANNELS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         file_byte,
  input  logic               end_of_file,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic signed [31:0] sample_value,
  output logic [4:0]         channel_index,
  output logic [18:0]        sample_rate,
  output logic [5:0]         channel_count,
  output logic [5:0]         bits_per_sample,
  output logic               is_float,
  output logic [2:0]         status_code,
  output logic               last
);

  logic       push_a, push_b, pop, pop_valid;
  item_t      item_a, item_b, pop_item;
  logic [1:0] free_slots;

  wrsp_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
    .clk, .rst, .in_valid, .file_byte, .end_of_file, .free_slots,
    .in_stall, .push_a, .item_a, .push_b, .item_b
  );

  wrsp_queue u_queue (
    .clk, .rst, .push_a, .item_a, .push_b, .item_b,
    .free_slots, .pop_valid, .pop_item, .pop
  );

  wrsp_back u_back (
    .clk, .rst, .pop_valid, .pop_item, .pop, .out_valid, .out_stall,
    .kind, .sample_value, .channel_index, .sample_rate, .channel_count,
    .bits_per_sample, .is_float, .status_code, .last
  );

endmodule
